@@ rtl/core/fha_pkg.sv @@
// Shared types and codes of the first-fit heap allocator.
package fha_pkg;

   localparam int ADDR_W = 32;
   localparam int SIZE_W = 32;

   // Request opcodes
   localparam logic [1:0] OP_ALLOC_BYTES  = 2'd0;
   localparam logic [1:0] OP_ALLOC_BLOCKS = 2'd1;
   localparam logic [1:0] OP_FREE         = 2'd2;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_ALREADY = 3'd1,
      ST_NOFIT   = 3'd2,
      ST_NULL    = 3'd3,
      ST_BOUNDS  = 3'd4,
      ST_BAD     = 3'd5,
      ST_FULL    = 3'd6
   } status_type;

   typedef struct packed {
      logic [1:0]        opcode;
      logic [ADDR_W-1:0] request_size;
      logic [ADDR_W-1:0] release_address;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0] granted_address;
      logic [2:0]        status;
      logic              all_free;
   } rsp_type;

endpackage

@@ rtl/core/fha_ceil_div.sv @@
// Request sizer: rounds a byte count up to whole blocks and scales the block count to bytes.
module fha_ceil_div #(
   parameter int BLOCK_BYTES = 64,
   parameter int NEED_W      = fha_pkg::ADDR_W + 1 + $clog2(BLOCK_BYTES + 1)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic                      by_blocks,
   input  logic [fha_pkg::ADDR_W-1:0] request_size,
   output logic                      done,
   output logic [NEED_W-1:0]         needed
);

   localparam int AW = fha_pkg::ADDR_W;
   localparam int RW = $clog2(BLOCK_BYTES);

   logic              done_ff, done_in;
   logic [NEED_W-1:0] needed_ff, needed_in;
   logic [AW:0]       rounded;

   // block size is a power of two: round up with an add and a mask, scale with a shift
   always_comb begin
      rounded   = {1'b0, request_size} + (AW+1)'(BLOCK_BYTES - 1);
      done_in   = start;
      needed_in = needed_ff;
      if (start) begin
         if (by_blocks) begin
            needed_in = NEED_W'(request_size) << RW;
         end else begin
            needed_in = NEED_W'({rounded[AW:RW], {RW{1'b0}}});
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= done_in;
      end
      needed_ff <= needed_in;
   end

   assign done   = done_ff;
   assign needed = needed_ff;

endmodule

@@ rtl/core/first_fit_heap_allocator.sv @@
// Top level of the first-fit heap allocator: sequencer, extent table and allocation table.
// One request is taken at a time; req_stall stays high until its result is loaded into the
// output register. Free extents live in an address-sorted table memory with one read port,
// and each visit to an entry takes a read state and then a compare state. BLOCK_BYTES must
// be a power of two. A request is accepted in the idle state and posts its result through
// a read state and a final state, waiting in the final state while the previous result is
// still held. An allocation first sizes the request, then scans extents in address order,
// and shifts later entries down when an extent is used up. A free scans the extents in two
// table passes, searches the live allocation slots between them, and shifts entries on
// insert and on each merge. After reset and after any csr write the init state rebuilds the
// table.
module first_fit_heap_allocator #(
   parameter int BLOCK_BYTES  = 64,
   parameter int HEADER_BYTES = 16,
   parameter int MAX_ALLOCS   = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  fha_pkg::req_type           req_payload,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output fha_pkg::rsp_type           rsp_payload,
   input  logic                       csr_write_en,
   input  logic                       csr_index,
   input  logic [fha_pkg::ADDR_W-1:0] csr_write_data
);

   localparam int A          = fha_pkg::ADDR_W;
   localparam int FREE_SLOTS = MAX_ALLOCS + 1;
   localparam int EW         = $clog2(FREE_SLOTS);
   localparam int CW         = $clog2(FREE_SLOTS + 1);
   localparam int SL_W       = $clog2(MAX_ALLOCS);
   localparam int SC_W       = $clog2(MAX_ALLOCS + 1);
   localparam int NW         = A + 1 + $clog2(BLOCK_BYTES + 1);
   localparam int XW         = A + 2;
   localparam logic [A-1:0] HDR    = A'(HEADER_BYTES);
   localparam logic [A:0]   SPLIT  = (A+1)'(HEADER_BYTES + BLOCK_BYTES);
   localparam logic [A-1:0] START0 = 32'h8000_56E0;
   localparam logic [A-1:0] END0   = 32'h8800_0000;

   typedef enum logic [20:0] {
      S_INIT   = 21'b1 << 0,
      S_IDLE   = 21'b1 << 1,
      S_DIV    = 21'b1 << 2,
      S_A_RD   = 21'b1 << 3,
      S_A_CMP  = 21'b1 << 4,
      S_RM_RD  = 21'b1 << 5,
      S_RM_WR  = 21'b1 << 6,
      S_F1_RD  = 21'b1 << 7,
      S_F1_CMP = 21'b1 << 8,
      S_F2_RD  = 21'b1 << 9,
      S_F2_CMP = 21'b1 << 10,
      S_F3_RD  = 21'b1 << 11,
      S_F3_CMP = 21'b1 << 12,
      S_UP_RD  = 21'b1 << 13,
      S_UP_WR  = 21'b1 << 14,
      S_PM_RD  = 21'b1 << 15,
      S_PM_CMP = 21'b1 << 16,
      S_NM_RD  = 21'b1 << 17,
      S_NM_CMP = 21'b1 << 18,
      S_FIN_RD = 21'b1 << 19,
      S_FIN    = 21'b1 << 20
   } state_type;

   state_type state_ff, state_in, ret_ff, ret_in;

   logic [A-1:0]      heap_start_ff, heap_start_in, heap_end_ff, heap_end_in;
   logic [A-1:0]      addr_ff, addr_in;
   logic [NW-1:0]     needed_ff, needed_in;
   logic [SL_W-1:0]   slot_ff, slot_in;
   logic [SC_W-1:0]   sl_ff, sl_in;
   logic [CW-1:0]     idx_ff, idx_in, k_ff, k_in, cnt_ff, cnt_in;
   logic [A-1:0]      size_ff, size_in, cur_a_ff, cur_a_in, cur_s_ff, cur_s_in;
   logic [A-1:0]      granted_ff, granted_in;
   fha_pkg::status_type status_ff, status_in;
   logic [MAX_ALLOCS-1:0] valid_ff, valid_in;
   logic              rsp_valid_ff, rsp_valid_in;
   fha_pkg::rsp_type  rsp_ff, rsp_in;

   // extent table memory: {header address, payload size}
   logic [2*A-1:0]    ext_mem [FREE_SLOTS];
   logic [2*A-1:0]    ext_rd_ff;
   logic              ext_re, ext_we;
   logic [EW-1:0]     ext_ra, ext_wa;
   logic [2*A-1:0]    ext_wd;

   // allocation table memory: {payload address, size}
   logic [2*A-1:0]    al_mem [MAX_ALLOCS];
   logic [2*A-1:0]    al_rd_ff;
   logic              al_re, al_we;
   logic [SL_W-1:0]   al_ra, al_wa;
   logic [2*A-1:0]    al_wd;

   logic              accept, out_free, free_found, window_ok, div_start, div_done;
   logic [SL_W-1:0]   free_slot;
   logic [A-1:0]      payload, ext_a, ext_s, al_a, al_s, hdr, rest;
   logic [NW-1:0]     div_needed;

   fha_ceil_div #(
      .BLOCK_BYTES(BLOCK_BYTES),
      .NEED_W     (NW)
   ) u_div (
      .clock       (clock),
      .reset       (reset),
      .start       (div_start),
      .by_blocks   (req_payload.opcode == fha_pkg::OP_ALLOC_BLOCKS),
      .request_size(req_payload.request_size),
      .done        (div_done),
      .needed      (div_needed)
   );

   // first unused allocation slot
   always_comb begin
      free_found = 1'b0;
      free_slot  = '0;
      for (int s = MAX_ALLOCS - 1; s >= 0; s--) begin
         if (!valid_ff[s]) begin
            free_found = 1'b1;
            free_slot  = SL_W'(s);
         end
      end
   end

   assign window_ok = {1'b0, heap_end_ff} >= ({1'b0, heap_start_ff} + {1'b0, HDR});
   assign payload   = window_ok ? (heap_end_ff - heap_start_ff - HDR) : '0;
   assign ext_a     = ext_rd_ff[2*A-1:A];
   assign ext_s     = ext_rd_ff[A-1:0];
   assign al_a      = al_rd_ff[2*A-1:A];
   assign al_s      = al_rd_ff[A-1:0];
   assign hdr       = addr_ff - HDR;
   assign rest      = ext_s - needed_ff[A-1:0];
   assign accept    = req_valid && (state_ff == S_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // sequencer
   always_comb begin
      state_in      = state_ff;
      ret_in        = ret_ff;
      heap_start_in = heap_start_ff;
      heap_end_in   = heap_end_ff;
      addr_in       = addr_ff;
      needed_in     = needed_ff;
      slot_in       = slot_ff;
      sl_in         = sl_ff;
      idx_in        = idx_ff;
      k_in          = k_ff;
      cnt_in        = cnt_ff;
      size_in       = size_ff;
      cur_a_in      = cur_a_ff;
      cur_s_in      = cur_s_ff;
      granted_in    = granted_ff;
      status_in     = status_ff;
      valid_in      = valid_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_in        = rsp_ff;
      ext_re        = 1'b0;
      ext_ra        = '0;
      ext_we        = 1'b0;
      ext_wa        = '0;
      ext_wd        = '0;
      al_re         = 1'b0;
      al_ra         = '0;
      al_we         = 1'b0;
      al_wa         = '0;
      al_wd         = '0;
      div_start     = 1'b0;

      unique case (state_ff)
         S_INIT: begin
            ext_we   = window_ok;
            ext_wd   = {heap_start_ff, payload};
            cnt_in   = window_ok ? CW'(1) : '0;
            state_in = S_IDLE;
         end
         S_IDLE: begin
            if (accept) begin
               addr_in    = req_payload.release_address;
               granted_in = '0;
               status_in  = fha_pkg::ST_OK;
               idx_in     = '0;
               state_in   = S_FIN_RD;
               unique case (req_payload.opcode) inside
                  fha_pkg::OP_ALLOC_BYTES, fha_pkg::OP_ALLOC_BLOCKS: begin
                     if (!free_found) begin
                        status_in = fha_pkg::ST_FULL;
                     end else begin
                        slot_in   = free_slot;
                        div_start = 1'b1;
                        state_in  = S_DIV;
                     end
                  end
                  fha_pkg::OP_FREE: begin
                     if (req_payload.release_address == '0) begin
                        status_in = fha_pkg::ST_NULL;
                     end else if (req_payload.release_address < heap_start_ff ||
                                  req_payload.release_address >= heap_end_ff) begin
                        status_in = fha_pkg::ST_BOUNDS;
                     end else begin
                        state_in = S_F1_RD;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_DIV: begin
            if (div_done) begin
               needed_in = div_needed;
               if (cnt_ff == '0 || div_needed > NW'(payload)) begin
                  status_in = fha_pkg::ST_NOFIT;
                  state_in  = S_FIN_RD;
               end else begin
                  state_in = S_A_RD;
               end
            end
         end
         // first-fit scan
         S_A_RD: begin
            if (idx_ff == cnt_ff) begin
               status_in = fha_pkg::ST_NOFIT;
               state_in  = S_FIN_RD;
            end else begin
               ext_re   = 1'b1;
               ext_ra   = idx_ff[EW-1:0];
               state_in = S_A_CMP;
            end
         end
         S_A_CMP: begin
            if (NW'(ext_s) >= needed_ff) begin
               granted_in        = ext_a + HDR;
               al_we             = 1'b1;
               al_wa             = slot_ff;
               valid_in[slot_ff] = 1'b1;
               if ({1'b0, rest} >= SPLIT) begin
                  ext_we   = 1'b1;
                  ext_wa   = idx_ff[EW-1:0];
                  ext_wd   = {ext_a + HDR + needed_ff[A-1:0], rest - HDR};
                  al_wd    = {ext_a + HDR, needed_ff[A-1:0]};
                  state_in = S_FIN_RD;
               end else begin
                  al_wd    = {ext_a + HDR, ext_s};
                  k_in     = idx_ff;
                  ret_in   = S_FIN_RD;
                  state_in = S_RM_RD;
               end
            end else begin
               idx_in   = idx_ff + CW'(1);
               state_in = S_A_RD;
            end
         end
         // remove entry k by shifting the tail down
         S_RM_RD: begin
            if (k_ff + CW'(1) < cnt_ff) begin
               ext_re   = 1'b1;
               ext_ra   = EW'(k_ff + CW'(1));
               state_in = S_RM_WR;
            end else begin
               cnt_in   = cnt_ff - CW'(1);
               state_in = ret_ff;
            end
         end
         S_RM_WR: begin
            ext_we   = 1'b1;
            ext_wa   = k_ff[EW-1:0];
            ext_wd   = ext_rd_ff;
            k_in     = k_ff + CW'(1);
            state_in = S_RM_RD;
         end
         // free: is the address already inside a free extent
         S_F1_RD: begin
            if (idx_ff == cnt_ff) begin
               sl_in    = '0;
               state_in = S_F2_RD;
            end else begin
               ext_re   = 1'b1;
               ext_ra   = idx_ff[EW-1:0];
               state_in = S_F1_CMP;
            end
         end
         S_F1_CMP: begin
            if (addr_ff < ext_a) begin
               sl_in    = '0;
               state_in = S_F2_RD;
            end else if (addr_ff > ext_a &&
                         {1'b0, addr_ff} <= ({1'b0, ext_a} + {1'b0, ext_s})) begin
               status_in = fha_pkg::ST_ALREADY;
               state_in  = S_FIN_RD;
            end else begin
               idx_in   = idx_ff + CW'(1);
               state_in = S_F1_RD;
            end
         end
         // free: look the address up among live allocations
         S_F2_RD: begin
            if (sl_ff == SC_W'(MAX_ALLOCS)) begin
               status_in = fha_pkg::ST_BAD;
               state_in  = S_FIN_RD;
            end else if (valid_ff[sl_ff[SL_W-1:0]]) begin
               al_re    = 1'b1;
               al_ra    = sl_ff[SL_W-1:0];
               state_in = S_F2_CMP;
            end else begin
               sl_in = sl_ff + SC_W'(1);
            end
         end
         S_F2_CMP: begin
            if (al_a == addr_ff) begin
               if (al_s == '0 || addr_ff < HDR) begin
                  status_in = fha_pkg::ST_BAD;
                  state_in  = S_FIN_RD;
               end else if (cnt_ff >= CW'(FREE_SLOTS)) begin
                  status_in = fha_pkg::ST_FULL;
                  state_in  = S_FIN_RD;
               end else begin
                  size_in                   = al_s;
                  valid_in[sl_ff[SL_W-1:0]] = 1'b0;
                  idx_in                    = '0;
                  state_in                  = S_F3_RD;
               end
            end else begin
               sl_in    = sl_ff + SC_W'(1);
               state_in = S_F2_RD;
            end
         end
         // free: find the insertion point
         S_F3_RD: begin
            if (idx_ff == cnt_ff) begin
               k_in     = cnt_ff;
               state_in = S_UP_RD;
            end else begin
               ext_re   = 1'b1;
               ext_ra   = idx_ff[EW-1:0];
               state_in = S_F3_CMP;
            end
         end
         S_F3_CMP: begin
            if (({1'b0, addr_ff} + {1'b0, size_ff}) <= {1'b0, ext_a}) begin
               k_in     = cnt_ff;
               state_in = S_UP_RD;
            end else begin
               idx_in   = idx_ff + CW'(1);
               state_in = S_F3_RD;
            end
         end
         // open a hole at idx and drop the block in
         S_UP_RD: begin
            if (k_ff > idx_ff) begin
               ext_re   = 1'b1;
               ext_ra   = EW'(k_ff - CW'(1));
               state_in = S_UP_WR;
            end else begin
               ext_we   = 1'b1;
               ext_wa   = idx_ff[EW-1:0];
               ext_wd   = {hdr, size_ff};
               cnt_in   = cnt_ff + CW'(1);
               cur_a_in = hdr;
               cur_s_in = size_ff;
               state_in = S_PM_RD;
            end
         end
         S_UP_WR: begin
            ext_we   = 1'b1;
            ext_wa   = k_ff[EW-1:0];
            ext_wd   = ext_rd_ff;
            k_in     = k_ff - CW'(1);
            state_in = S_UP_RD;
         end
         // join with the extent below
         S_PM_RD: begin
            if (idx_ff != '0) begin
               ext_re   = 1'b1;
               ext_ra   = EW'(idx_ff - CW'(1));
               state_in = S_PM_CMP;
            end else begin
               state_in = S_NM_RD;
            end
         end
         S_PM_CMP: begin
            if ((XW'(ext_a) + XW'(HDR) + XW'(ext_s)) == XW'(hdr)) begin
               ext_we   = 1'b1;
               ext_wa   = EW'(idx_ff - CW'(1));
               ext_wd   = {ext_a, ext_s + HDR + cur_s_ff};
               cur_a_in = ext_a;
               cur_s_in = ext_s + HDR + cur_s_ff;
               k_in     = idx_ff;
               idx_in   = idx_ff - CW'(1);
               ret_in   = S_NM_RD;
               state_in = S_RM_RD;
            end else begin
               state_in = S_NM_RD;
            end
         end
         // join with the extent above
         S_NM_RD: begin
            if (idx_ff + CW'(1) < cnt_ff) begin
               ext_re   = 1'b1;
               ext_ra   = EW'(idx_ff + CW'(1));
               state_in = S_NM_CMP;
            end else begin
               state_in = S_FIN_RD;
            end
         end
         S_NM_CMP: begin
            if ((XW'(cur_a_ff) + XW'(HDR) + XW'(cur_s_ff)) == XW'(ext_a)) begin
               ext_we   = 1'b1;
               ext_wa   = idx_ff[EW-1:0];
               ext_wd   = {cur_a_ff, cur_s_ff + HDR + ext_s};
               k_in     = idx_ff + CW'(1);
               ret_in   = S_FIN_RD;
               state_in = S_RM_RD;
            end else begin
               state_in = S_FIN_RD;
            end
         end
         // read entry 0 for the all-free flag, then post the result
         S_FIN_RD: begin
            ext_re   = 1'b1;
            ext_ra   = '0;
            state_in = S_FIN;
         end
         S_FIN: begin
            if (out_free) begin
               rsp_in.granted_address = granted_ff;
               rsp_in.status          = status_ff;
               rsp_in.all_free        = (cnt_ff == CW'(1)) && (ext_a == heap_start_ff) &&
                                        window_ok && (ext_s >= payload);
               rsp_valid_in           = 1'b1;
               state_in               = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      // register writes rebuild the store
      if (csr_write_en) begin
         if (csr_index) begin
            heap_end_in = csr_write_data;
         end else begin
            heap_start_in = csr_write_data;
         end
         valid_in = '0;
         state_in = S_INIT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_INIT;
         ret_ff        <= S_FIN_RD;
         heap_start_ff <= START0;
         heap_end_ff   <= END0;
         cnt_ff        <= '0;
         valid_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         ret_ff        <= ret_in;
         heap_start_ff <= heap_start_in;
         heap_end_ff   <= heap_end_in;
         cnt_ff        <= cnt_in;
         valid_ff      <= valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      addr_ff    <= addr_in;
      needed_ff  <= needed_in;
      slot_ff    <= slot_in;
      sl_ff      <= sl_in;
      idx_ff     <= idx_in;
      k_ff       <= k_in;
      size_ff    <= size_in;
      cur_a_ff   <= cur_a_in;
      cur_s_ff   <= cur_s_in;
      granted_ff <= granted_in;
      status_ff  <= status_in;
      rsp_ff     <= rsp_in;
   end

   // extent table memory
   always_ff @(posedge clock) begin
      if (ext_we) begin
         ext_mem[ext_wa] <= ext_wd;
      end
      if (ext_re) begin
         ext_rd_ff <= ext_mem[ext_ra];
      end
   end

   // allocation table memory
   always_ff @(posedge clock) begin
      if (al_we) begin
         al_mem[al_wa] <= al_wd;
      end
      if (al_re) begin
         al_rd_ff <= al_mem[al_ra];
      end
   end

   assign req_stall   = (state_ff != S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule
